// ----- rtl/bsta_pkg.sv -----
// ============================================================================
// bsta_pkg: shared types and constants for the body section task arbiter
// Field widths, command and result codes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package bsta_pkg;

  localparam int CmdW   = 2;
  localparam int ModW   = 3;
  localparam int PrioW  = 3;
  localparam int TagW   = 8;
  localparam int SecW   = 2;
  localparam int KindW  = 2;
  localparam int SlotW  = 4;
  localparam int GrpW   = 3;
  localparam int NumSec = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_ACK   = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_WAITING  = 2'd0,
    STAT_SELECTED = 2'd1,
    STAT_IGNORED  = 2'd2
  } slot_stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD,
    S_ACK,
    S_FIN,
    S_ARB_START,
    S_ARB_CHECK,
    S_SEL,
    S_RESOLVE,
    S_COMMIT,
    S_GRANT,
    S_NOTE
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ModW-1:0]  module_id;
    logic [PrioW-1:0] head_priority;
    logic [PrioW-1:0] arms_priority;
    logic [PrioW-1:0] legs_priority;
    logic             head_required;
    logic             arms_required;
    logic             legs_required;
    logic             head_commit;
    logic             arms_commit;
    logic             legs_commit;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] result_kind;
    logic [TagW-1:0]  request_tag;
    logic [SecW-1:0]  section;
    logic             granted;
    logic [ModW-1:0]  owner_module;
    logic [GrpW-1:0]  joint_group;
    logic [SlotW-1:0] task_slot;
    logic             rejected;
    logic             last;
  } res_t;

  typedef struct packed {
    logic capture;
    logic add_step;
    logic ack_emit;
    logic fin_step;
    logic arb_start;
    logic sel_clear;
    logic sel_step;
    logic resolve;
    logic commit;
    logic grant_emit;
    logic note_emit;
    logic note_next;
    logic unbind;
  } dp_cmd_t;

  typedef struct packed {
    logic [CmdW-1:0] op;
    logic            dirty;
    logic            k_last;
    logic            scan_last;
    logic            arb_done;
    logic            done_empty;
    logic            note_match;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bsta_req_if.sv -----
// ============================================================================
// bsta_req_if: input channel of the arbiter
// Valid/ready handshake carrying one command transaction.
// ============================================================================
`default_nettype none

interface bsta_req_if;
  import bsta_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [ModW-1:0]  module_id;
  logic [PrioW-1:0] head_priority;
  logic [PrioW-1:0] arms_priority;
  logic [PrioW-1:0] legs_priority;
  logic             head_required;
  logic             arms_required;
  logic             legs_required;
  logic             head_commit;
  logic             arms_commit;
  logic             legs_commit;

  modport source (
    output valid, cmd, module_id, head_priority, arms_priority, legs_priority,
           head_required, arms_required, legs_required,
           head_commit, arms_commit, legs_commit,
    input  ready
  );

  modport sink (
    input  valid, cmd, module_id, head_priority, arms_priority, legs_priority,
           head_required, arms_required, legs_required,
           head_commit, arms_commit, legs_commit,
    output ready
  );

  modport monitor (
    input valid, ready, cmd, module_id, head_priority, arms_priority,
          legs_priority, head_required, arms_required, legs_required,
          head_commit, arms_commit, legs_commit
  );

endinterface

`default_nettype wire

// ----- rtl/bsta_res_if.sv -----
// ============================================================================
// bsta_res_if: result channel of the arbiter
// Valid/ready handshake carrying one result transaction.
// ============================================================================
`default_nettype none

interface bsta_res_if;
  import bsta_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] result_kind;
  logic [TagW-1:0]  request_tag;
  logic [SecW-1:0]  section;
  logic             granted;
  logic [ModW-1:0]  owner_module;
  logic [GrpW-1:0]  joint_group;
  logic [SlotW-1:0] task_slot;
  logic             rejected;
  logic             last;

  modport source (
    output valid, result_kind, request_tag, section, granted, owner_module,
           joint_group, task_slot, rejected, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, request_tag, section, granted, owner_module,
           joint_group, task_slot, rejected, last,
    output ready
  );

  modport monitor (
    input valid, ready, result_kind, request_tag, section, granted,
          owner_module, joint_group, task_slot, rejected, last
  );

endinterface

`default_nettype wire

// ----- rtl/bsta_ctrl.sv -----
// ============================================================================
// bsta_ctrl: sequencing state machine
// Walks each accepted transaction through its datapath steps.
// ============================================================================
`default_nettype none

module bsta_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bsta_pkg::dp_stat_t  stat_i,
  output bsta_pkg::dp_cmd_t   cmd_o
);
  import bsta_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat_i.op)
          CMD_REQUEST: state_d = S_ADD;
          CMD_FINISH:  state_d = S_FIN;
          CMD_TICK:    state_d = stat_i.dirty ? S_ARB_START : S_IDLE;
          default:     state_d = S_IDLE;
        endcase
      end
      S_ADD: begin
        if (stat_i.k_last) state_d = S_ACK;
      end
      S_ACK: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_FIN: begin
        if (stat_i.scan_last) state_d = S_IDLE;
      end
      S_ARB_START: state_d = S_ARB_CHECK;
      S_ARB_CHECK: state_d = stat_i.arb_done ? S_COMMIT : S_SEL;
      S_SEL: begin
        if (stat_i.scan_last) state_d = S_RESOLVE;
      end
      S_RESOLVE: state_d = S_ARB_CHECK;
      S_COMMIT:  state_d = S_GRANT;
      S_GRANT: begin
        if (stat_i.out_free && stat_i.k_last) state_d = S_NOTE;
      end
      S_NOTE: begin
        if (stat_i.done_empty) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_ADD:       cmd_o.add_step  = 1'b1;
      S_ACK:       cmd_o.ack_emit  = stat_i.out_free;
      S_FIN:       cmd_o.fin_step  = 1'b1;
      S_ARB_START: cmd_o.arb_start = 1'b1;
      S_ARB_CHECK: cmd_o.sel_clear = !stat_i.arb_done;
      S_SEL:       cmd_o.sel_step  = 1'b1;
      S_RESOLVE:   cmd_o.resolve   = 1'b1;
      S_COMMIT:    cmd_o.commit    = 1'b1;
      S_GRANT:     cmd_o.grant_emit = stat_i.out_free;
      S_NOTE: begin
        if (stat_i.done_empty) begin
          cmd_o.unbind = 1'b1;
        end else if (stat_i.note_match) begin
          cmd_o.note_emit = stat_i.out_free;
        end else begin
          cmd_o.note_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bsta_datapath.sv -----
// ============================================================================
// bsta_datapath: task table, ranking scan, grant resolve and result register
// Per-slot lanes with a slot scan counter; one command per cycle.
// ============================================================================
`default_nettype none

module bsta_datapath #(
  parameter int TASK_SLOTS      = 16,
  parameter int PRIORITY_LEVELS = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bsta_pkg::req_t      req_i,
  input  bsta_pkg::dp_cmd_t   cmd_i,
  output bsta_pkg::dp_stat_t  stat_o,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output bsta_pkg::res_t      res_o
);
  import bsta_pkg::*;

  localparam int N       = TASK_SLOTS;
  localparam int IW      = $clog2(N);
  localparam int CW      = $clog2(N + 1);
  localparam int PrioCap = (1 << PrioW) - 1;
  localparam int PrioMax = (PRIORITY_LEVELS - 1 > PrioCap) ? PrioCap : PRIORITY_LEVELS - 1;
  localparam int KeyW    = 1 + PrioW + IW;

  // slot table
  logic [N-1:0]     valid_q, valid_d, bind_q, bind_d, comm_q, comm_d;
  logic [N-1:0]     cwant_q, req_q;
  logic [SecW-1:0]  sec_q  [N];
  logic [PrioW-1:0] prio_q [N];
  logic [ModW-1:0]  mod_q  [N];
  logic [TagW-1:0]  tag_q  [N];
  slot_stat_e       stat_q [N];
  slot_stat_e       stat_d [N];
  logic [IW-1:0]    arr_q  [N];
  logic [IW-1:0]    arr_d  [N];

  logic [CW-1:0]    count_q, count_d;
  logic [TagW-1:0]  tagc_q, tagc_d;
  logic             dirty_q, dirty_d;

  // latched transaction
  logic [CmdW-1:0]  op_q, op_d;
  logic [ModW-1:0]  mid_q, mid_d;
  logic [PrioW-1:0] pr_q [NumSec];
  logic [PrioW-1:0] pr_d [NumSec];
  logic [NumSec-1:0] rq_q, rq_d, cm_q, cm_d;
  logic             rej_q, rej_d;

  // sequencing
  logic [1:0]       k_q, k_d;
  logic [IW-1:0]    scan_q, scan_d, rank_q, rank_d;
  logic [IW-1:0]    first_q, first_d;
  logic             first_v_q, first_v_d;
  logic [IW-1:0]    best_q, best_d;
  logic             best_v_q, best_v_d;
  logic [KeyW-1:0]  best_key_q, best_key_d;
  logic [N-1:0]     cand_q, cand_d;
  logic [NumSec-1:0] hold_v_q, hold_v_d;
  logic [IW-1:0]    hold_q [NumSec];
  logic [IW-1:0]    hold_d [NumSec];

  logic             out_v_q, out_v_d;
  res_t             out_q, out_d;

  // fill port
  logic             fill_en;
  logic [IW-1:0]    fill_idx;

  // combinational helpers
  logic [IW-1:0]    free_idx;
  logic [N-1:0]     f_oh, dep, conflict, gset, done_v, match_v;
  logic [N-1:0]     secm [NumSec];
  logic [NumSec-1:0] sec_hit;
  logic [IW-1:0]    g_idx [NumSec];
  logic             any_dep, dep_ok, refuse;
  logic [IW-1:0]    note_idx;
  logic             out_free;

  function automatic logic [IW-1:0] enc(input logic [N-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = 0; i < N; i++) begin
      if (v[i]) r = r | IW'(i);
    end
    return r;
  endfunction

  function automatic logic [PrioW-1:0] sat(input logic [PrioW-1:0] p);
    return (p > PrioW'(PrioMax)) ? PrioW'(PrioMax) : p;
  endfunction

  assign out_free = !out_v_q || res_ready_i;

  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  // dependency and grant set of the current leader (best_q)
  always_comb begin
    f_oh = '0;
    f_oh[best_q] = 1'b1;
    for (int t = 0; t < N; t++) begin
      dep[t] = (IW'(t) != best_q) && valid_q[t] && bind_q[best_q] && bind_q[t] &&
               req_q[t] && (tag_q[t] == tag_q[best_q]);
      conflict[t] = hold_v_q[sec_q[t]] && (hold_q[sec_q[t]] != IW'(t));
    end
    any_dep = |dep;
    dep_ok  = ~|(dep & conflict);
    refuse  = 1'b0;
    if (comm_q[best_q] || !any_dep) begin
      gset = f_oh;
    end else if (dep_ok) begin
      gset = f_oh | dep;
    end else begin
      gset   = '0;
      refuse = 1'b1;
    end
    for (int j = 0; j < NumSec; j++) begin
      for (int t = 0; t < N; t++) begin
        secm[j][t] = (sec_q[t] == SecW'(j));
      end
      sec_hit[j] = |(gset & secm[j]);
      g_idx[j]   = enc(gset & secm[j]);
    end
  end

  always_comb begin
    for (int t = 0; t < N; t++) begin
      done_v[t]  = valid_q[t] && !comm_q[t] && (stat_q[t] == STAT_SELECTED);
      match_v[t] = done_v[t] && (arr_q[t] == rank_q);
    end
    note_idx = enc(match_v);
  end

  always_comb begin
    logic [1:0]      need;
    logic [CW:0]     free_w;
    logic            drop_en;
    logic [IW-1:0]   drop_idx;
    logic            emit;
    res_t            emit_res;
    logic [KeyW-1:0] key_s;
    logic [IW-1:0]   h;
    logic [PrioW-1:0] pk;

    valid_d = valid_q;  bind_d = bind_q;  comm_d = comm_q;
    stat_d  = stat_q;   arr_d  = arr_q;
    count_d = count_q;  tagc_d = tagc_q;  dirty_d = dirty_q;
    op_d = op_q;  mid_d = mid_q;  pr_d = pr_q;  rq_d = rq_q;  cm_d = cm_q;
    rej_d = rej_q;
    k_d = k_q;  scan_d = scan_q;  rank_d = rank_q;
    first_d = first_q;  first_v_d = first_v_q;
    best_d = best_q;  best_v_d = best_v_q;  best_key_d = best_key_q;
    cand_d = cand_q;  hold_v_d = hold_v_q;  hold_d = hold_q;
    out_d = out_q;
    fill_en = 1'b0;  fill_idx = free_idx;
    drop_en = 1'b0;  drop_idx = '0;
    emit = 1'b0;  emit_res = '0;
    need = '0;  free_w = '0;  key_s = '0;  h = '0;  pk = '0;

    if (cmd_i.capture) begin
      need = 2'(req_i.head_priority != '0) + 2'(req_i.arms_priority != '0) +
             2'(req_i.legs_priority != '0);
      free_w = (CW + 1)'(N) - (CW + 1)'(count_q);
      rej_d  = (CW + 1)'(need) > free_w;
      op_d   = req_i.cmd;
      mid_d  = req_i.module_id;
      pr_d[0] = sat(req_i.head_priority);
      pr_d[1] = sat(req_i.arms_priority);
      pr_d[2] = sat(req_i.legs_priority);
      rq_d = {req_i.legs_required, req_i.arms_required, req_i.head_required};
      cm_d = {req_i.legs_commit, req_i.arms_commit, req_i.head_commit};
      k_d = '0;  scan_d = '0;  first_v_d = 1'b0;  first_d = '0;
    end

    if (cmd_i.add_step) begin
      pk = pr_q[k_q];
      if (!rej_q && (pk != '0)) begin
        fill_en = 1'b1;
        valid_d[free_idx] = 1'b1;
        bind_d[free_idx]  = 1'b1;
        comm_d[free_idx]  = 1'b0;
        stat_d[free_idx]  = STAT_WAITING;
        arr_d[free_idx]   = IW'(count_q);
        count_d = count_q + 1'b1;
        if (!first_v_q) begin
          first_v_d = 1'b1;
          first_d   = free_idx;
        end
      end
      k_d = k_q + 1'b1;
    end

    if (cmd_i.ack_emit) begin
      emit = 1'b1;
      emit_res.result_kind  = KIND_ACK;
      emit_res.request_tag  = tagc_q;
      emit_res.owner_module = mid_q;
      emit_res.task_slot    = SlotW'(first_q);
      emit_res.rejected     = rej_q;
      emit_res.last         = 1'b1;
      if (!rej_q && first_v_q) begin
        tagc_d  = tagc_q + 1'b1;
        dirty_d = 1'b1;
      end
    end

    if (cmd_i.fin_step) begin
      if (valid_q[scan_q] && comm_q[scan_q] && (mod_q[scan_q] == mid_q)) begin
        drop_en  = 1'b1;
        drop_idx = scan_q;
        dirty_d  = 1'b1;
      end
      scan_d = scan_q + 1'b1;
    end

    if (cmd_i.arb_start) begin
      dirty_d  = 1'b0;
      cand_d   = valid_q;
      hold_v_d = '0;
    end

    if (cmd_i.sel_clear) begin
      scan_d   = '0;
      best_v_d = 1'b0;
    end

    if (cmd_i.sel_step) begin
      key_s = {comm_q[scan_q], prio_q[scan_q], ~arr_q[scan_q]};
      if (cand_q[scan_q] && (!best_v_q || (key_s > best_key_q))) begin
        best_v_d   = 1'b1;
        best_d     = scan_q;
        best_key_d = key_s;
      end
      scan_d = scan_q + 1'b1;
    end

    if (cmd_i.resolve) begin
      for (int t = 0; t < N; t++) begin
        if (gset[t]) begin
          stat_d[t] = STAT_SELECTED;
        end else if (cand_q[t] && sec_hit[sec_q[t]]) begin
          stat_d[t] = STAT_IGNORED;
        end
        if (refuse && (f_oh[t] || dep[t])) stat_d[t] = STAT_IGNORED;
        if (f_oh[t] || (cand_q[t] && sec_hit[sec_q[t]])) cand_d[t] = 1'b0;
      end
      for (int j = 0; j < NumSec; j++) begin
        if (sec_hit[j]) begin
          hold_v_d[j] = 1'b1;
          hold_d[j]   = g_idx[j];
        end
      end
    end

    if (cmd_i.commit) begin
      for (int t = 0; t < N; t++) begin
        for (int j = 0; j < NumSec; j++) begin
          if (hold_v_q[j] && (hold_q[j] == IW'(t)) && cwant_q[t]) comm_d[t] = 1'b1;
        end
      end
      k_d    = '0;
      rank_d = '0;
    end

    if (cmd_i.grant_emit) begin
      h = hold_q[k_q];
      emit = 1'b1;
      emit_res.result_kind = KIND_GRANT;
      emit_res.section     = SecW'(k_q);
      emit_res.last        = (k_q == 2'(NumSec - 1)) && (done_v == '0);
      if (hold_v_q[k_q]) begin
        emit_res.granted      = 1'b1;
        emit_res.request_tag  = tag_q[h];
        emit_res.owner_module = mod_q[h];
        emit_res.task_slot    = SlotW'(h);
        for (int j = 0; j < NumSec; j++) begin
          emit_res.joint_group[j] = hold_v_q[j] && (mod_q[hold_q[j]] == mod_q[h]);
        end
      end
      k_d = k_q + 1'b1;
    end

    if (cmd_i.note_emit) begin
      emit = 1'b1;
      emit_res.result_kind  = KIND_DONE;
      emit_res.request_tag  = tag_q[note_idx];
      emit_res.section      = sec_q[note_idx];
      emit_res.owner_module = mod_q[note_idx];
      emit_res.task_slot    = SlotW'(note_idx);
      emit_res.last         = ((done_v & ~match_v) == '0);
      drop_en  = 1'b1;
      drop_idx = note_idx;
      dirty_d  = 1'b1;
    end

    if (cmd_i.note_next) rank_d = rank_q + 1'b1;

    if (cmd_i.unbind) bind_d = '0;

    // slot removal: close up the age ranks behind it
    if (drop_en) begin
      valid_d[drop_idx] = 1'b0;
      bind_d[drop_idx]  = 1'b0;
      for (int t = 0; t < N; t++) begin
        if (valid_q[t] && (arr_q[t] > arr_q[drop_idx])) arr_d[t] = arr_q[t] - 1'b1;
      end
      if (count_q != '0) count_d = count_q - 1'b1;
    end

    if (emit) begin
      out_v_d = 1'b1;
      out_d   = emit_res;
    end else if (res_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      bind_q  <= '0;
      count_q <= '0;
      tagc_q  <= '0;
      dirty_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      bind_q  <= bind_d;
      count_q <= count_d;
      tagc_q  <= tagc_d;
      dirty_q <= dirty_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    comm_q <= comm_d;  stat_q <= stat_d;  arr_q <= arr_d;
    op_q <= op_d;  mid_q <= mid_d;  pr_q <= pr_d;  rq_q <= rq_d;  cm_q <= cm_d;
    rej_q <= rej_d;
    k_q <= k_d;  scan_q <= scan_d;  rank_q <= rank_d;
    first_q <= first_d;  first_v_q <= first_v_d;
    best_q <= best_d;  best_v_q <= best_v_d;  best_key_q <= best_key_d;
    cand_q <= cand_d;  hold_v_q <= hold_v_d;  hold_q <= hold_d;
    out_q <= out_d;
    if (fill_en) begin
      sec_q[fill_idx]   <= SecW'(k_q);
      prio_q[fill_idx]  <= pr_q[k_q];
      mod_q[fill_idx]   <= mid_q;
      tag_q[fill_idx]   <= tagc_q;
      cwant_q[fill_idx] <= cm_q[k_q];
      req_q[fill_idx]   <= rq_q[k_q];
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.dirty      = dirty_q;
  assign stat_o.k_last     = (k_q == 2'(NumSec - 1));
  assign stat_o.scan_last  = (scan_q == IW'(N - 1));
  assign stat_o.arb_done   = (cand_q == '0) || (&hold_v_q);
  assign stat_o.done_empty = (done_v == '0);
  assign stat_o.note_match = (match_v != '0);
  assign stat_o.out_free   = out_free;

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ----- rtl/body_section_task_arbiter_top.sv -----
// Request: from acceptance to the acknowledge it passes capture, decode, one
//   step per section and the result register. Module finished: a scan of all slots.
// Dirty tick: each selection round is a ranking scan of one slot per cycle, then
//   resolve, up to one round per candidate; then 3 grant results, then the rank
//   steps and completion notices. Clean tick: capture and decode only.
// One transaction at a time. Reset is asynchronous; no clearing pass is needed.
// ============================================================================
// body_section_task_arbiter_top: body section task arbiter
// Grants head, arms and legs to requesting modules from a task table.
// ============================================================================
`default_nettype none

module body_section_task_arbiter_top #(
  parameter int TASK_SLOTS      = 16,
  parameter int PRIORITY_LEVELS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bsta_req_if.sink   req_i,
  bsta_res_if.source res_o
);
  import bsta_pkg::*;

  // Controller: sequences each input transaction through the datapath
  // (add tasks, drop finished modules, or run an arbitration round by round).
  // Datapath: slot table lanes, ranking scan, grant resolve, output register.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  req_t     req_bus;
  res_t     res_bus;
  logic     in_ready;
  logic     res_valid;

  // Pack the incoming transaction for the datapath.
  assign req_bus.cmd           = req_i.cmd;
  assign req_bus.module_id     = req_i.module_id;
  assign req_bus.head_priority = req_i.head_priority;
  assign req_bus.arms_priority = req_i.arms_priority;
  assign req_bus.legs_priority = req_i.legs_priority;
  assign req_bus.head_required = req_i.head_required;
  assign req_bus.arms_required = req_i.arms_required;
  assign req_bus.legs_required = req_i.legs_required;
  assign req_bus.head_commit   = req_i.head_commit;
  assign req_bus.arms_commit   = req_i.arms_commit;
  assign req_bus.legs_commit   = req_i.legs_commit;

  // Input is taken only when the controller is idle; a result may still be
  // waiting in the output register at that time.
  assign req_i.ready = in_ready;

  bsta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bsta_datapath #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res_bus)
  );

  // Result transaction straight from the output register.
  assign res_o.valid        = res_valid;
  assign res_o.result_kind  = res_bus.result_kind;
  assign res_o.request_tag  = res_bus.request_tag;
  assign res_o.section      = res_bus.section;
  assign res_o.granted      = res_bus.granted;
  assign res_o.owner_module = res_bus.owner_module;
  assign res_o.joint_group  = res_bus.joint_group;
  assign res_o.task_slot    = res_bus.task_slot;
  assign res_o.rejected     = res_bus.rejected;
  assign res_o.last         = res_bus.last;

endmodule

`default_nettype wire

// ----- rtl/bsta_checker.sv -----
// ============================================================================
// bsta_checker: port-level checks for the arbiter
// Watches the two channels over time; bound onto the top level.
// ============================================================================
`default_nettype none

module bsta_checker (
  input wire         clk_i,
  input wire         rst_ni,
  bsta_req_if.sink   req_m,
  bsta_res_if.source res_m
);

  // Stalled result holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_m.valid && !res_m.ready |=> res_m.valid && $stable(res_m.request_tag) &&
    $stable(res_m.result_kind) && $stable(res_m.last))
    else $error("result changed while stalled");

  // One transaction in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_m.valid && req_m.ready |=> !req_m.ready)
    else $error("input taken while busy");

  // More results of the same transaction still to come.
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_m.valid && res_m.ready && !res_m.last |=> !req_m.ready)
    else $error("input ready before last result");

endmodule

bind body_section_task_arbiter_top bsta_checker u_bsta_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_m  (req_i),
  .res_m  (res_o)
);

`default_nettype wire
